// ===== sv/lmcs_pkg.sv =====
package lmcs_pkg;

  // Default number of chained 8x8 modules
  localparam int MAX_MODULES_DEF = 4;

  // Input item fields
  localparam int COL_W   = 5;
  localparam int BIT_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 3;
  localparam int IN_DATA_W = 24;

  // Result word fields
  localparam int ROWREG_W   = 4;
  localparam int MODNUM_W   = 2;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROTATE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLIP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODULES = 2'd2;
  localparam logic [CFG_W-1:0]     MODULES_RST = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE     = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_FILL      = 3'd3,
    ACT_CLEAR_ALL = 3'd4
  } act_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_fill;
    logic sweep_write;
    logic take_item;
    logic upd_read;
    logic upd_write;
    logic frame_init;
    logic col_init;
    logic col_step;
    logic word_load;
    logic word_next;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic refresh;
    logic sweep_last;
    logic cols_done;
    logic word_last;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/led_matrix_column_store_row_refresh.sv =====
// Column store and row refresh for a chain of up to MAX_MODULES 8x8 LED modules.
// Each input transaction updates the store of column bytes (write a column, set
// or clear one bit, fill or clear every column) and, with refresh set, then
// sends a frame: for rows 1..8, one word per module in use from the highest
// module down to module 0, each row byte transposed from the module's eight
// columns in the orientation chosen by the rotate and flip registers. Items are
// taken one at a time; spare action codes leave the store alone. A column
// write, set or clear reads the column and writes it back; fill and clear-all
// sweep the store, one store entry written per cycle. A refresh then sends
// 8 * modules in use words: the store's single read port yields one column
// byte per cycle, eight reads per row byte. The word register lets the next
// word be built while the previous one waits on m_axis_tready. After reset
// the block clears the store before s_axis_tready first rises; configuration
// writes are taken at any time (cfg_ready stays high) and belong in idle
// periods.
module led_matrix_column_store_row_refresh import lmcs_pkg::*; #(
  parameter int MAX_MODULES = MAX_MODULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // column_index, bit_index, column_value, refresh
  input  logic [ACT_W-1:0]      s_axis_tuser,  // action
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // row_register, row_bits, module_number
  output logic                  m_axis_tuser,  // end_of_load
  output logic                  m_axis_tlast,  // last word of the frame
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  lmcs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .cmd     (cmd),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready)
  );

  lmcs_datapath #(
    .MAX_MODULES(MAX_MODULES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cfg_write(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

endmodule

// ===== sv/lmcs_ram.sv =====
module lmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lmcs_ctrl.sv =====
module lmcs_ctrl import lmcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd,
  input  logic  in_valid,
  output logic  in_ready
);

  typedef enum logic [6:0] {
    S_SWEEP  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_MODIFY = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_COLS   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_SWEEP: begin
        cmd.sweep_write = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_CHECK;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ACT_WRITE, ACT_SET, ACT_CLEAR: begin
            cmd.upd_read = 1'b1;
            state_next   = S_MODIFY;
          end
          ACT_FILL: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_fill  = 1'b1;
            state_next      = S_SWEEP;
          end
          ACT_CLEAR_ALL: begin
            cmd.sweep_start = 1'b1;
            state_next      = S_SWEEP;
          end
          default: begin
            state_next = S_CHECK;
          end
        endcase
      end
      S_MODIFY: begin
        cmd.upd_write = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (stat.refresh) begin
          cmd.frame_init = 1'b1;
          cmd.col_init   = 1'b1;
          state_next     = S_COLS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COLS: begin
        cmd.col_step = 1'b1;
        if (stat.cols_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.word_load = 1'b1;
          if (stat.word_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.word_next = 1'b1;
            cmd.col_init  = 1'b1;
            state_next    = S_COLS;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lmcs_datapath.sv =====
module lmcs_datapath import lmcs_pkg::*; #(
  parameter int MAX_MODULES = MAX_MODULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [ACT_W-1:0]      in_user,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_user,
  output logic                  out_last
);

  localparam int DEPTH = 8 * MAX_MODULES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int XW    = ((AW > COL_W) ? AW : COL_W) + 1;
  localparam int NW    = 4;

  // configuration
  logic             rotate;
  logic             flip;
  logic [CFG_W-1:0] modules;

  // current item
  act_t              item_act;
  logic [COL_W-1:0]  item_col;
  logic [BIT_W-1:0]  item_bit;
  logic [BYTE_W-1:0] item_value;
  logic              item_refresh;

  // fill / clear sweep
  logic [AW-1:0]     sweep_addr;
  logic [BYTE_W-1:0] sweep_val;

  // frame walk and transpose
  logic [2:0]        row;
  logic [MW-1:0]     mod;
  logic [3:0]        k;
  logic              rd_pend;
  logic [2:0]        rd_k;
  logic [BYTE_W-1:0] acc;

  logic [XW-1:0]     col_ext;
  logic [AW-1:0]     item_addr;
  logic              in_range;
  logic [NW-1:0]     mods_ext;
  logic [NW-1:0]     n_active;
  logic [MW-1:0]     top_mod;
  logic [2:0]        src;
  logic [2:0]        acc_pos;
  logic [BYTE_W-1:0] bit_mask;
  logic [BYTE_W-1:0] upd_data;
  logic [AW-1:0]     col_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_q;

  lmcs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_comb begin
    col_ext   = XW'(item_col);
    item_addr = col_ext[AW-1:0];
    in_range  = col_ext < XW'(DEPTH);

    mods_ext = NW'(modules);
    if (mods_ext == '0) begin
      n_active = NW'(1);
    end else if (mods_ext > NW'(MAX_MODULES)) begin
      n_active = NW'(MAX_MODULES);
    end else begin
      n_active = mods_ext;
    end
    top_mod = MW'(n_active - NW'(1));

    src      = (rotate ^ flip) ? ~row : row;
    acc_pos  = rotate ? ~rd_k : rd_k;
    bit_mask = 8'b1 << item_bit;

    case (item_act)
      ACT_SET:   upd_data = ram_q | bit_mask;
      ACT_CLEAR: upd_data = ram_q & ~bit_mask;
      default:   upd_data = item_value;
    endcase

    col_addr  = AW'({mod, k[2:0]});
    ram_we    = cmd.sweep_write | (cmd.upd_write & in_range);
    ram_waddr = cmd.sweep_write ? sweep_addr : item_addr;
    ram_wdata = cmd.sweep_write ? sweep_val : upd_data;
    ram_raddr = cmd.upd_read ? item_addr : col_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate  <= 1'b0;
      flip    <= 1'b0;
      modules <= MODULES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROTATE:  rotate  <= cfg_data[0];
        REG_FLIP:    flip    <= cfg_data[0];
        REG_MODULES: modules <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_refresh <= 1'b0;
    end else if (cmd.take_item) begin
      item_refresh <= in_data[COL_W+BIT_W+BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_act   <= act_t'(in_user);
      item_col   <= in_data[COL_W-1:0];
      item_bit   <= in_data[COL_W+BIT_W-1:COL_W];
      item_value <= in_data[COL_W+BIT_W+BYTE_W-1:COL_W+BIT_W];
    end
  end

  // start at zero after reset so the first sweep clears the store
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_val  <= '0;
    end else if (cmd.sweep_start) begin
      sweep_addr <= '0;
      sweep_val  <= cmd.sweep_fill ? 8'hFF : 8'h00;
    end else if (cmd.sweep_write) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_init) begin
      row <= '0;
      mod <= top_mod;
    end else if (cmd.word_next) begin
      if (mod == '0) begin
        mod <= top_mod;
        row <= row + 3'd1;
      end else begin
        mod <= mod - MW'(1);
      end
    end
  end

  // one column byte read per cycle, its bit lands in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      k       <= '0;
    end else if (cmd.col_init) begin
      rd_pend <= 1'b0;
      k       <= '0;
    end else if (cmd.col_step) begin
      if (k != 4'd8) begin
        rd_pend <= 1'b1;
        k       <= k + 4'd1;
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_step && k != 4'd8) begin
      rd_k <= k[2:0];
    end
    if (rd_pend) begin
      acc[acc_pos] <= ram_q[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.word_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_load) begin
      out_data <= {2'b00, MODNUM_W'(mod), acc, ROWREG_W'(row) + ROWREG_W'(1)};
      out_user <= (mod == '0);
      out_last <= (mod == '0) && (row == 3'd7);
    end
  end

  always_comb begin
    stat.act        = item_act;
    stat.refresh    = item_refresh;
    stat.sweep_last = (sweep_addr == AW'(DEPTH - 1));
    stat.cols_done  = (k == 4'd8) && !rd_pend;
    stat.word_last  = (mod == '0) && (row == 3'd7);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lmcs_pkg::*;

  // Spare codes: actions the block must ignore, and a register index with no register.
  localparam logic [ACT_W-1:0]     ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0]     ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0]     ACT_SPARE_HI  = 3'd7;
  localparam logic [REG_IDX_W-1:0] REG_SPARE     = 2'd3;

  localparam int STORE_COLS   = 8 * MAX_MODULES_DEF;
  localparam int ITEMS_PHASE  = 64;
  localparam int SETTLE_WAIT  = 64;    // covers a fill or clear-all still in flight
  localparam int TAIL_WAIT    = 200;
  localparam int HOLD_CYCLES  = 1500;  // long receiver stall to back up the input
  localparam int STALL_LIMIT  = 20000;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [COL_W-1:0]  col;
    logic [BIT_W-1:0]  bit_pos;
    logic [BYTE_W-1:0] value;
    logic              refresh;
  } update_t;

  typedef struct packed {
    logic [ROWREG_W-1:0] row_reg;
    logic [BYTE_W-1:0]   bits;
    logic [MODNUM_W-1:0] module_num;
    logic                end_load;
    logic                frame_end;
  } row_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [ACT_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  led_matrix_column_store_row_refresh u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the display: column bytes and the three registers.
  logic [BYTE_W-1:0] col_bytes [STORE_COLS];
  logic              rotate_sh  = 1'b0;
  logic              flip_sh    = 1'b0;
  logic [CFG_W-1:0]  modules_sh = MODULES_RST;

  update_t   updates_to_send [$];
  row_word_t row_words_due [$];
  update_t   cur_update;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;
  int updates_sent  = 0;
  int frames_due    = 0;
  int words_checked = 0;
  int cfg_writes    = 0;

  initial begin
    for (int i = 0; i < STORE_COLS; i++) col_bytes[i] = '0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Transpose one module's eight columns into row byte r for the current orientation.
  function automatic logic [BYTE_W-1:0] row_from_columns(input int module_idx, input int r);
    int src;
    int c;
    logic [BYTE_W-1:0] acc;
    acc = '0;
    src = (rotate_sh != flip_sh) ? 7 - r : r;
    for (int k = 0; k < 8; k++) begin
      c = rotate_sh ? 7 - k : k;
      acc[k] = col_bytes[module_idx * 8 + c][src];
    end
    return acc;
  endfunction

  // Apply one update to the shadow store and queue the frame it triggers.
  task automatic apply_update(input update_t u);
    int n;
    row_word_t w;
    case (u.action)
      ACT_WRITE:     col_bytes[u.col] = u.value;
      ACT_SET:       col_bytes[u.col][u.bit_pos] = 1'b1;
      ACT_CLEAR:     col_bytes[u.col][u.bit_pos] = 1'b0;
      ACT_FILL:      for (int i = 0; i < STORE_COLS; i++) col_bytes[i] = 8'hFF;
      ACT_CLEAR_ALL: for (int i = 0; i < STORE_COLS; i++) col_bytes[i] = 8'h00;
      default: ;
    endcase
    updates_sent++;
    if (u.refresh) begin
      frames_due++;
      // Clamp the module count to 1..MAX_MODULES
      n = modules_sh;
      if (n < 1) n = 1;
      if (n > MAX_MODULES_DEF) n = MAX_MODULES_DEF;
      for (int r = 0; r < 8; r++) begin
        for (int m = n - 1; m >= 0; m--) begin
          w.row_reg    = ROWREG_W'(r + 1);
          w.bits       = row_from_columns(m, r);
          w.module_num = MODNUM_W'(m);
          w.end_load   = (m == 0);
          w.frame_end  = (m == 0) && (r == 7);
          row_words_due.push_back(w);
        end
      end
    end
  endtask

  // Driver: hold tvalid until the transaction is taken, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_update(cur_update);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (updates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_update = updates_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, cur_update.refresh, cur_update.value,
                            cur_update.bit_pos, cur_update.col};
          s_axis_tuser  <= cur_update.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Compare one received word against the oldest expectation.
  task automatic check_row_word();
    row_word_t want;
    if (row_words_due.size() == 0) begin
      flag_mismatch("unexpected word", m_axis_tdata, 0);
    end else begin
      want = row_words_due.pop_front();
      words_checked++;
      if (m_axis_tdata[3:0] !== want.row_reg)
        flag_mismatch("row_register", m_axis_tdata[3:0], want.row_reg);
      if (m_axis_tdata[11:4] !== want.bits)
        flag_mismatch("row_bits", m_axis_tdata[11:4], want.bits);
      if (m_axis_tdata[13:12] !== want.module_num)
        flag_mismatch("module_number", m_axis_tdata[13:12], want.module_num);
      if (m_axis_tuser !== want.end_load)
        flag_mismatch("end_of_load", m_axis_tuser, want.end_load);
      if (m_axis_tlast !== want.frame_end)
        flag_mismatch("last", m_axis_tlast, want.frame_end);
    end
  endtask

  // Monitor: check each output transaction and pace tready, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_row_word();
      if (hold_req && !hold_taken) begin
        hold_taken    <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles with no transaction anywhere.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR t=%0t no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("led_matrix_column_store_row_refresh: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_update(input logic [ACT_W-1:0] action, input int col, input int bit_pos,
                              input int value, input bit refresh);
    update_t u;
    u.action  = action;
    u.col     = COL_W'(col);
    u.bit_pos = BIT_W'(bit_pos);
    u.value   = BYTE_W'(value);
    u.refresh = refresh;
    updates_to_send.push_back(u);
  endtask

  // Random updates: mostly column edits, a few whole-store actions and spare codes.
  task automatic queue_random_updates(input int count);
    int pick;
    logic [ACT_W-1:0] act;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)      act = ACT_WRITE;
      else if (pick < 65) act = ACT_SET;
      else if (pick < 85) act = ACT_CLEAR;
      else if (pick < 90) act = ACT_FILL;
      else if (pick < 94) act = ACT_CLEAR_ALL;
      else                act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      queue_update(act, $urandom_range(STORE_COLS - 1), $urandom_range(7),
                   $urandom_range(255), ($urandom_range(99) < 22));
    end
  endtask

  // Write one register; update the shadow at the accepting edge.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROTATE:  rotate_sh  = val[0];
      REG_FLIP:    flip_sh    = val[0];
      REG_MODULES: modules_sh = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_display(input logic [CFG_W-1:0] rot, input logic [CFG_W-1:0] flip,
                             input logic [CFG_W-1:0] mods);
    write_reg(REG_ROTATE, rot);
    write_reg(REG_FLIP, flip);
    write_reg(REG_MODULES, mods);
    @(negedge clk);
  endtask

  // Wait until every update is taken and every word is back, then let the block settle.
  task automatic drain();
    @(negedge clk);
    while (updates_to_send.size() != 0 || s_axis_tvalid || row_words_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] rot, input logic [CFG_W-1:0] flip,
                                  input logic [CFG_W-1:0] mods, input int send_pct,
                                  input int recv_pct);
    set_display(rot, flip, mods);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random_updates(ITEMS_PHASE);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset orientation, all four modules, field extremes and every action.
    send_idle_pct = 24;
    recv_idle_pct = 64;
    queue_update(ACT_WRITE, 0, 0, 8'h81, 1'b0);
    queue_update(ACT_WRITE, 7, 7, 8'h01, 1'b1);
    queue_update(ACT_WRITE, STORE_COLS - 1, 0, 8'hFF, 1'b0);
    queue_update(ACT_WRITE, 16, 5, 8'h5A, 1'b1);
    queue_update(ACT_SET, 3, 0, 8'h00, 1'b0);
    queue_update(ACT_SET, STORE_COLS - 1, 7, 8'hFF, 1'b1);
    queue_update(ACT_CLEAR, STORE_COLS - 1, 7, 8'h00, 1'b0);
    queue_update(ACT_CLEAR, 0, 0, 8'hFF, 1'b1);
    queue_update(ACT_SET, 24, 3, 8'hFF, 1'b0);
    queue_update(ACT_FILL, STORE_COLS - 1, 7, 8'hFF, 1'b1);
    queue_update(ACT_CLEAR, 15, 4, 8'h00, 1'b1);
    queue_update(ACT_CLEAR_ALL, 0, 0, 8'h00, 1'b1);
    // Spare action codes leave the store alone but still honor refresh
    queue_update(ACT_WRITE, 9, 2, 8'hC3, 1'b0);
    queue_update(ACT_SPARE_LO, 9, 7, 8'h00, 1'b1);
    queue_update(ACT_SPARE_MID, 10, 1, 8'hFF, 1'b0);
    queue_update(ACT_SPARE_HI, 31, 7, 8'hFF, 1'b1);
    queue_update(ACT_WRITE, 12, 0, 8'hFF, 1'b0);
    queue_update(ACT_WRITE, 20, 0, 8'h80, 1'b0);
    queue_update(ACT_SET, 27, 6, 8'h00, 1'b0);
    queue_update(ACT_WRITE, 5, 0, 8'h00, 1'b1);
    drain();

    // Random phases across orientations and module counts, out-of-range counts included.
    run_random_phase(3'd1, 3'd0, 3'd4, 24, 64);
    run_random_phase(3'd0, 3'd1, 3'd1, 24, 64);
    run_random_phase(3'd1, 3'd1, 3'd2, 24, 64);
    run_random_phase(3'd0, 3'd0, 3'd0, 64, 24);
    run_random_phase(3'b111, 3'd0, 3'd7, 64, 24);
    write_reg(REG_SPARE, 3'b111);
    run_random_phase(3'b110, 3'b011, 3'd3, 64, 24);

    // Last phase: no idling, and one long receiver hold-off to fill the block.
    hold_req = 1'b1;
    run_random_phase(CFG_W'($urandom_range(1)), CFG_W'($urandom_range(1)),
                     CFG_W'($urandom_range(1, MAX_MODULES_DEF)), 0, 0);

    repeat (TAIL_WAIT) @(negedge clk);

    $display("Covered %0d updates, %0d frames, %0d words checked, %0d register writes.",
             updates_sent, frames_due, words_checked, cfg_writes);
    $display("Orientations: all four; module counts 0 to 4 and 7, zero and seven clamped.");
    if (mismatches == 0 && row_words_due.size() == 0) begin
      $display("led_matrix_column_store_row_refresh: match");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, row_words_due.size());
      $display("led_matrix_column_store_row_refresh: mismatch");
    end
    $finish;
  end

endmodule

// ===== led_matrix_column_store_row_refresh.f =====
sv/lmcs_pkg.sv
sv/lmcs_ram.sv
sv/lmcs_ctrl.sv
sv/lmcs_datapath.sv
sv/led_matrix_column_store_row_refresh.sv
dv/tb_top.sv
